// ===== hw/rtl/ppt_pkg.sv =====
package ppt_pkg;

	localparam int NUM_COEFS = 8;
	localparam int COEF_W = 32;
	localparam int PT_W = 16;
	localparam int PROD_W = COEF_W + PT_W;
	localparam int SUM_W = PROD_W + 1;
	localparam int NUM_W = SUM_W + 5;
	localparam int DEN_W = SUM_W + 1;
	localparam int QB = 17;
	localparam int REM_W = DEN_W + QB + 1;
	localparam int IDX_W = $clog2(NUM_COEFS);

	localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(1) <<< 28;
	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) <<< 24;
	localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;
	localparam logic [QB-1:0] POS_LIMIT = QB'(32767);
	localparam logic [QB-1:0] NEG_LIMIT = QB'(32768);
	localparam logic signed [PT_W-1:0] OUT_MAX = 16'sh7fff;
	localparam logic signed [PT_W-1:0] OUT_MIN = 16'sh8000;

	typedef enum logic [IDX_W-1:0] {
		REG_A, REG_B, REG_C, REG_D, REG_E, REG_F, REG_G, REG_H
	} reg_idx_t;

	typedef struct packed {
		logic signed [PT_W-1:0] in_x;
		logic signed [PT_W-1:0] in_y;
	} in_beat_t;

	typedef struct packed {
		logic signed [PT_W-1:0] out_x;
		logic signed [PT_W-1:0] out_y;
		logic                   degenerate;
		logic                   saturated;
	} out_beat_t;

endpackage

// ===== hw/rtl/projective_point_transform.sv =====
// channel | direction | handshake            | beat
// src     | in        | src_valid, src_stall | in_x, in_y (Q12.4)
// dst     | out       | dst_valid, dst_stall | out_x, out_y, degenerate, saturated
// cfg     | in        | cfg_we               | cfg_index, cfg_data (Q8.24)
// one beat per cycle while the pipeline is not held; stages: products, sums, 20 divider stages
// (setup, range check, 17 quotient bits, saturation into the output register)
// the whole pipeline holds while dst_valid is high and dst_stall is high
// reset clears valid bits and loads the identity homography
module projective_point_transform (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 src_valid,
	output logic                                 src_stall,
	input  ppt_pkg::in_beat_t                    src,
	output logic                                 dst_valid,
	input  logic                                 dst_stall,
	output ppt_pkg::out_beat_t                   dst,
	input  logic                                 cfg_we,
	input  logic [ppt_pkg::IDX_W-1:0]            cfg_index,
	input  logic [ppt_pkg::COEF_W-1:0]           cfg_data
);

	localparam int PROD_W = ppt_pkg::PROD_W;
	localparam int SUM_W = ppt_pkg::SUM_W;

	logic signed [ppt_pkg::COEF_W-1:0] coef_q [ppt_pkg::NUM_COEFS];
	logic en;
	logic vld_s1, vld_s2;
	logic signed [PROD_W-1:0] pa_s1, pb_s1, pd_s1, pe_s1, pg_s1, ph_s1;
	logic signed [SUM_W-1:0] u_s2, v_s2, w_s2;
	logic vx, vy;
	logic signed [ppt_pkg::PT_W-1:0] ox, oy;
	logic sx, sy, zx, zy;

	assign en = !dst_valid || !dst_stall;
	assign src_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppt_pkg::NUM_COEFS; i++) begin
				coef_q[i] <= (i == int'(ppt_pkg::REG_A) || i == int'(ppt_pkg::REG_E)) ?
					ppt_pkg::COEF_ONE : ppt_pkg::COEF_ZERO;
			end
		end else if (cfg_we) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= src_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1 <= PROD_W'(coef_q[ppt_pkg::REG_A] * src.in_x);
			pb_s1 <= PROD_W'(coef_q[ppt_pkg::REG_B] * src.in_y);
			pd_s1 <= PROD_W'(coef_q[ppt_pkg::REG_D] * src.in_x);
			pe_s1 <= PROD_W'(coef_q[ppt_pkg::REG_E] * src.in_y);
			pg_s1 <= PROD_W'(coef_q[ppt_pkg::REG_G] * src.in_x);
			ph_s1 <= PROD_W'(coef_q[ppt_pkg::REG_H] * src.in_y);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s2 <= SUM_W'(pa_s1) + SUM_W'(pb_s1)
				+ (SUM_W'(coef_q[ppt_pkg::REG_C]) <<< 4);
			v_s2 <= SUM_W'(pd_s1) + SUM_W'(pe_s1)
				+ (SUM_W'(coef_q[ppt_pkg::REG_F]) <<< 4);
			w_s2 <= SUM_W'(pg_s1) + SUM_W'(ph_s1) + ppt_pkg::ONE_Q28;
		end
	end

	ppt_div u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(vld_s2),
		.num(u_s2), .den(w_s2),
		.res_vld(vx), .res(ox), .res_sat(sx), .res_zero(zx)
	);

	ppt_div u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(vld_s2),
		.num(v_s2), .den(w_s2),
		.res_vld(vy), .res(oy), .res_sat(sy), .res_zero(zy)
	);

	assign dst_valid = vx & vy;
	assign dst.out_x = ox;
	assign dst.out_y = oy;
	assign dst.degenerate = zx & zy;
	assign dst.saturated = sx | sy;

endmodule

// ===== hw/rtl/ppt_div.sv =====
module ppt_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld,
	input  logic signed [ppt_pkg::SUM_W-1:0]    num,
	input  logic signed [ppt_pkg::SUM_W-1:0]    den,
	output logic                                res_vld,
	output logic signed [ppt_pkg::PT_W-1:0]     res,
	output logic                                res_sat,
	output logic                                res_zero
);

	localparam int QB = ppt_pkg::QB;
	localparam int REM_W = ppt_pkg::REM_W;
	localparam int DEN_W = ppt_pkg::DEN_W;

	logic [ppt_pkg::SUM_W-1:0] num_mag, den_mag;
	logic [ppt_pkg::NUM_W-1:0] n_full;

	logic [REM_W-1:0] n_s1;
	logic [DEN_W-1:0] d_s1;
	logic neg_s1, zero_s1, vld_s1;

	logic [REM_W-1:0] rem_s [0:QB];
	logic [DEN_W-1:0] d_s [0:QB];
	logic [QB-1:0] q_s [0:QB];
	logic neg_s [0:QB];
	logic zero_s [0:QB];
	logic ovf_s [0:QB];
	logic vld_s [0:QB];

	logic [QB-1:0] q_fin;
	logic fin_sat;
	logic signed [ppt_pkg::PT_W-1:0] fin_val;

	// magnitudes, rounding offset folded into the dividend
	assign num_mag = num[ppt_pkg::SUM_W-1] ? ppt_pkg::SUM_W'(-num) : num;
	assign den_mag = den[ppt_pkg::SUM_W-1] ? ppt_pkg::SUM_W'(-den) : den;
	assign n_full = {num_mag, 5'b0} + ppt_pkg::NUM_W'(den_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= REM_W'(n_full);
			d_s1 <= {den_mag, 1'b0};
			neg_s1 <= num[ppt_pkg::SUM_W-1] ^ den[ppt_pkg::SUM_W-1];
			zero_s1 <= (den == '0);
		end
	end

	// overflow check: quotient of 2^17 or more
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= n_s1;
			d_s[0] <= d_s1;
			q_s[0] <= '0;
			neg_s[0] <= neg_s1;
			zero_s[0] <= zero_s1;
			ovf_s[0] <= (n_s1 >= {1'b0, d_s1, {QB{1'b0}}});
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < QB; k++) begin : g_step
		localparam int SH = QB - 1 - k;
		logic [REM_W-1:0] dsh;
		logic take;
		assign dsh = REM_W'({d_s[k], {SH{1'b0}}});
		assign take = (rem_s[k] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? rem_s[k] - dsh : rem_s[k];
				q_s[k+1] <= {q_s[k][QB-2:0], take};
				d_s[k+1] <= d_s[k];
				neg_s[k+1] <= neg_s[k];
				zero_s[k+1] <= zero_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign q_fin = q_s[QB];

	always_comb begin
		if (neg_s[QB]) begin
			fin_sat = ovf_s[QB] || (q_fin > ppt_pkg::NEG_LIMIT);
			fin_val = fin_sat ? ppt_pkg::OUT_MIN : ppt_pkg::PT_W'(-q_fin);
		end else begin
			fin_sat = ovf_s[QB] || (q_fin > ppt_pkg::POS_LIMIT);
			fin_val = fin_sat ? ppt_pkg::OUT_MAX : ppt_pkg::PT_W'(q_fin);
		end
		if (zero_s[QB]) begin
			fin_sat = 1'b0;
			fin_val = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld <= 1'b0;
		end else if (en) begin
			res_vld <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= fin_val;
			res_sat <= fin_sat;
			res_zero <= zero_s[QB];
		end
	end

endmodule

// ===== hw/rtl/ppt_chk.sv =====
module ppt_chk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       src_valid,
	input  logic                       src_stall,
	input  ppt_pkg::in_beat_t          src,
	input  logic                       dst_valid,
	input  logic                       dst_stall,
	input  ppt_pkg::out_beat_t         dst,
	input  logic                       cfg_we,
	input  logic [ppt_pkg::IDX_W-1:0]  cfg_index,
	input  logic [ppt_pkg::COEF_W-1:0] cfg_data
);

	logic unused_ok;
	assign unused_ok = ^{src_valid, src, cfg_we, cfg_index, cfg_data};

	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst))
		else $error("stalled dst beat changed");

	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |-> src_stall)
		else $error("src taken while dst stalled");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst.degenerate |->
			dst.out_x == '0 && dst.out_y == '0 && !dst.saturated)
		else $error("degenerate beat not zeroed");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst.saturated |->
			dst.out_x == ppt_pkg::OUT_MAX || dst.out_x == ppt_pkg::OUT_MIN ||
			dst.out_y == ppt_pkg::OUT_MAX || dst.out_y == ppt_pkg::OUT_MIN)
		else $error("saturated beat not at a limit");

	a_rst: assert property (@(posedge clk) !arst_n |-> !dst_valid)
		else $error("dst valid in reset");

endmodule

bind projective_point_transform ppt_chk u_ppt_chk (.*);
